[rtl/mcpp_pkg.sv]
// shared types, codes and constants of the max credit process picker
`timescale 1ns / 1ps

package mcpp_pkg;

    localparam int ENTRY_COUNT = 32;

    localparam logic [3:0] FLAG_SLEEP = 4'b0001;
    localparam logic [3:0] FLAG_FREE  = 4'b1000;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_SCHED = 1'b1
    } func_t;

    typedef struct packed {
        logic [3:0]  flags;
        logic [7:0]  credit;
        logic [7:0]  prio;
        logic [31:0] wake;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t RESET_ENTRY = '{
        flags:  FLAG_FREE,
        credit: 8'd0,
        prio:   8'd0,
        wake:   32'd0
    };

    typedef struct packed {
        func_t       func;
        logic [4:0]  entry_index;
        logic [3:0]  entry_flags;
        logic [7:0]  entry_credit;
        logic [7:0]  entry_priority;
        logic [31:0] entry_wake;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [4:0] selected;
        logic       changed;
        logic       refilled;
        logic       none_ready;
    } rsp_t;

    // result of the per-entry unit for one table entry
    typedef struct packed {
        entry_t ent;
        logic   we;
        logic   ready;
        logic   better;
    } unit_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REFILL,
        ST_FINISH
    } state_t;

endpackage

[rtl/mcpp_stream_if.sv]
// valid/ready stream interface carrying one payload
`timescale 1ns / 1ps

interface mcpp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

[rtl/max_credit_process_picker.sv]
// top level of the max credit process picker
// write item: table written on the transfer, result loaded in the finish state once the
//   output register is free; schedule item: a scan walk, plus a second walk when credits
//   are reloaded, then finish; each walk steps through the table ram one entry a cycle
// one item at a time; a finished result may wait in the output register meanwhile
// reset clears entry valid bits at once so every entry reads as a free slot, pick 0
`timescale 1ns / 1ps

module max_credit_process_picker #(
    parameter int NUM_ENTRIES = mcpp_pkg::ENTRY_COUNT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mcpp_stream_if.sink          req,
    mcpp_stream_if.source        rsp
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam logic [8:0]       NUM_LIMIT = 9'(NUM_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NUM_ENTRIES);

    mcpp_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    mcpp_pkg::func_t        func_reg, func_next;
    logic [31:0]            now_reg, now_next;
    logic                   best_found_reg, best_found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [7:0]             best_credit_reg, best_credit_next;
    logic                   refilled_reg, refilled_next;
    logic [4:0]             pick_reg, pick_next;
    logic                   out_valid_reg, out_valid_next;
    mcpp_pkg::rsp_t         out_data_reg, out_data_next;
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic                   rd_valid_reg;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [IDX_W-1:0]       ram_raddr;
    logic [mcpp_pkg::ENTRY_W-1:0] ram_wdata;
    logic [mcpp_pkg::ENTRY_W-1:0] ram_rdata;

    mcpp_pkg::entry_t       rd_ent;
    mcpp_pkg::unit_res_t    unit_res;
    logic [CNT_W-1:0]       cnt_prev;
    logic [IDX_W-1:0]       proc_idx;
    logic                   proc;
    logic                   last;
    logic                   out_free;
    logic                   idx_in_range;
    logic [4:0]             new_sel;

    assign cnt_prev     = cnt_reg - CNT_W'(1);
    assign proc_idx     = cnt_prev[IDX_W-1:0];
    assign proc         = (cnt_reg != '0);
    assign last         = (cnt_reg == CNT_LAST);
    assign ram_raddr    = cnt_reg[IDX_W-1:0];
    assign out_free     = !out_valid_reg || rsp.ready;
    assign idx_in_range = (9'(req.data.entry_index) < NUM_LIMIT);
    assign new_sel      = 5'(best_idx_reg);

    // never-written entries read as free slots
    assign rd_ent = rd_valid_reg ? mcpp_pkg::entry_t'(ram_rdata) : mcpp_pkg::RESET_ENTRY;

    mcpp_ram #(
        .WIDTH (mcpp_pkg::ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mcpp_entry_unit u_unit (
        .ent         (rd_ent),
        .refill      (state_reg == mcpp_pkg::ST_REFILL),
        .now         (now_reg),
        .best_credit (best_credit_reg),
        .res         (unit_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcpp_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.data.func == mcpp_pkg::FUNC_SCHED) ?
                                 mcpp_pkg::ST_SCAN : mcpp_pkg::ST_FINISH;
                end
            end
            mcpp_pkg::ST_SCAN:
            begin
                if (last)
                begin
                    state_next = best_found_next ? mcpp_pkg::ST_FINISH : mcpp_pkg::ST_REFILL;
                end
            end
            mcpp_pkg::ST_REFILL:
            begin
                if (last)
                begin
                    state_next = mcpp_pkg::ST_FINISH;
                end
            end
            mcpp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mcpp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcpp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: handshake and table write port
    always_comb
    begin
        req.ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = proc_idx;
        ram_wdata = unit_res.ent;
        unique case (state_reg)
            mcpp_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                ram_waddr = IDX_W'(req.data.entry_index);
                ram_wdata = {req.data.entry_flags, req.data.entry_credit,
                             req.data.entry_priority, req.data.entry_wake};
                if (req.valid && (req.data.func == mcpp_pkg::FUNC_WRITE) && idx_in_range)
                begin
                    ram_we = 1'b1;
                end
            end
            mcpp_pkg::ST_SCAN,
            mcpp_pkg::ST_REFILL:
            begin
                ram_we = proc && unit_res.we;
            end
            mcpp_pkg::ST_FINISH:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next         = cnt_reg;
        func_next        = func_reg;
        now_next         = now_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_credit_next = best_credit_reg;
        refilled_next    = refilled_reg;
        pick_next        = pick_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            mcpp_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next        = req.data.func;
                    now_next         = req.data.now;
                    cnt_next         = '0;
                    best_found_next  = 1'b0;
                    best_credit_next = 8'd0;
                    refilled_next    = 1'b0;
                end
            end
            mcpp_pkg::ST_SCAN,
            mcpp_pkg::ST_REFILL:
            begin
                if (proc && unit_res.better)
                begin
                    best_found_next  = 1'b1;
                    best_idx_next    = proc_idx;
                    best_credit_next = unit_res.ent.credit;
                end
                if (proc && unit_res.ready && (state_reg == mcpp_pkg::ST_REFILL))
                begin
                    refilled_next = 1'b1;
                end
                cnt_next = last ? '0 : cnt_reg + CNT_W'(1);
            end
            mcpp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.selected   = pick_reg;
                    out_data_next.changed    = 1'b0;
                    out_data_next.refilled   = 1'b0;
                    out_data_next.none_ready = 1'b0;
                    if (func_reg == mcpp_pkg::FUNC_SCHED)
                    begin
                        out_data_next.refilled = refilled_reg;
                        if (best_found_reg)
                        begin
                            pick_next              = new_sel;
                            out_data_next.selected = new_sel;
                            out_data_next.changed  = (new_sel != pick_reg);
                        end
                        else
                        begin
                            out_data_next.none_ready = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mcpp_pkg::ST_IDLE;
            cnt_reg        <= '0;
            func_reg       <= mcpp_pkg::FUNC_WRITE;
            best_found_reg <= 1'b0;
            refilled_reg   <= 1'b0;
            pick_reg       <= 5'd0;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            func_reg       <= func_next;
            best_found_reg <= best_found_next;
            refilled_reg   <= refilled_next;
            pick_reg       <= pick_next;
            out_valid_reg  <= out_valid_next;
            rd_valid_reg   <= valid_reg[ram_raddr];
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        best_idx_reg    <= best_idx_next;
        best_credit_reg <= best_credit_next;
        out_data_reg    <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // a kept pick never reports a change
    a_none_ready_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.none_ready |-> !rsp.data.changed)
        else $error("none_ready result reports a changed pick");

    // a schedule transfer makes the block busy for the walk
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.data.func == mcpp_pkg::FUNC_SCHED) |=> !req.ready)
        else $error("ready high right after a schedule transfer");

    // write items never report a reload
    a_write_no_refill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) && (func_reg == mcpp_pkg::FUNC_WRITE) |-> !rsp.data.refilled)
        else $error("write item result reports a reload");

    // the walk counter stays within the table plus the drain step
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("walk counter past the table");

endmodule

[rtl/mcpp_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mcpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/mcpp_entry_unit.sv]
// shared per-entry unit: wake check, refill and credit compare for one entry
`timescale 1ns / 1ps

module mcpp_entry_unit (
    input  mcpp_pkg::entry_t    ent,
    input  logic                refill,
    input  logic [31:0]         now,
    input  logic [7:0]          best_credit,
    output mcpp_pkg::unit_res_t res
);

    logic       wake_hit;

    assign wake_hit = ((ent.flags & mcpp_pkg::FLAG_SLEEP) != 4'd0) && (ent.wake <= now);

    always_comb
    begin
        res.ent = ent;
        res.we  = 1'b0;
        if (refill)
        begin
            if (ent.flags == 4'd0)
            begin
                res.ent.credit = ent.prio;
                res.we         = 1'b1;
            end
        end
        else if (wake_hit)
        begin
            res.ent.flags = ent.flags & ~mcpp_pkg::FLAG_SLEEP;
            res.ent.wake  = 32'd0;
            res.we        = 1'b1;
        end
        // one comparator serves both passes
        res.ready  = (res.ent.flags == 4'd0);
        res.better = res.ready && (res.ent.credit > best_credit);
    end

endmodule

[tb/tb.sv]
// self-checking testbench for the max credit process picker
`timescale 1ns / 1ps

module tb;

    localparam int NUM       = mcpp_pkg::ENTRY_COUNT;
    localparam int ITEMS     = 900;
    localparam int LIMIT     = 500000;
    localparam int HOLD_AT   = 400;
    localparam int HOLD_LEN  = 300;
    localparam int SETTLE    = 2 * NUM + 40;

    logic clk;
    logic rst_n;

    mcpp_stream_if #(.T(mcpp_pkg::req_t)) req_if ();
    mcpp_stream_if #(.T(mcpp_pkg::rsp_t)) rsp_if ();

    max_credit_process_picker #(
        .NUM_ENTRIES (NUM)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // scheduler state as the block should hold it
    logic [3:0]  tbl_flags  [NUM];
    logic [7:0]  tbl_credit [NUM];
    logic [7:0]  tbl_prio   [NUM];
    logic [31:0] tbl_wake   [NUM];
    logic [4:0]  cur_pick;

    mcpp_pkg::req_t request_q [$];
    mcpp_pkg::rsp_t expected_picks [$];

    int   sent_count;
    int   mismatch_count;
    int   cycle_count;
    int   send_gap;
    int   recv_gap;
    logic hold_active;
    int   hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int best_ready();
        int best;
        logic [7:0] top;
        best = -1;
        top = 8'd0;
        for (int i = 0; i < NUM; i++)
        begin
            if (tbl_flags[i] == 4'd0 && tbl_credit[i] > top)
            begin
                top = tbl_credit[i];
                best = i;
            end
        end
        return best;
    endfunction

    function automatic mcpp_pkg::rsp_t predict_pick(mcpp_pkg::req_t it);
        mcpp_pkg::rsp_t r;
        int best;
        logic [4:0] prev;
        prev = cur_pick;
        r = '0;
        if (it.func == mcpp_pkg::FUNC_WRITE)
        begin
            if (int'(it.entry_index) < NUM)
            begin
                tbl_flags[it.entry_index]  = it.entry_flags;
                tbl_credit[it.entry_index] = it.entry_credit;
                tbl_prio[it.entry_index]   = it.entry_priority;
                tbl_wake[it.entry_index]   = it.entry_wake;
            end
        end
        else
        begin
            for (int i = 0; i < NUM; i++)
            begin
                if ((tbl_flags[i] & mcpp_pkg::FLAG_SLEEP) != 4'd0 && tbl_wake[i] <= it.now)
                begin
                    tbl_flags[i] = tbl_flags[i] & ~mcpp_pkg::FLAG_SLEEP;
                    tbl_wake[i] = 32'd0;
                end
            end
            best = best_ready();
            if (best < 0)
            begin
                // every ready entry is out of credit: reload from priority
                for (int i = 0; i < NUM; i++)
                begin
                    if (tbl_flags[i] == 4'd0)
                    begin
                        tbl_credit[i] = tbl_prio[i];
                        r.refilled = 1'b1;
                    end
                end
                best = best_ready();
            end
            if (best < 0)
                r.none_ready = 1'b1;
            else
                cur_pick = best[4:0];
        end
        r.selected = cur_pick;
        r.changed = (cur_pick != prev);
        return r;
    endfunction

    task automatic report(string msg);
        if (mismatch_count < 40)
            $display("tb: mismatch: %s (t=%0t)", msg, $realtime);
        mismatch_count++;
    endtask

    task automatic check_pick(mcpp_pkg::rsp_t got);
        mcpp_pkg::rsp_t want;
        if (expected_picks.size() == 0)
        begin
            report($sformatf("result with none pending, selected %0d", got.selected));
        end
        else
        begin
            want = expected_picks.pop_front();
            if (got.selected !== want.selected)
                report($sformatf("selected %0d, want %0d", got.selected, want.selected));
            if (got.changed !== want.changed)
                report($sformatf("changed %0b, want %0b", got.changed, want.changed));
            if (got.refilled !== want.refilled)
                report($sformatf("refilled %0b, want %0b", got.refilled, want.refilled));
            if (got.none_ready !== want.none_ready)
                report($sformatf("none_ready %0b, want %0b", got.none_ready, want.none_ready));
        end
    endtask

    // mostly short gaps, a few long ones, and stretches with none at all
    function automatic int next_gap();
        int r;
        if ((sent_count / 128) % 4 == 2)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_write(int idx, logic [3:0] flags, logic [7:0] cr, logic [7:0] pr,
                             logic [31:0] wake);
        mcpp_pkg::req_t it;
        it = '0;
        it.func           = mcpp_pkg::FUNC_WRITE;
        it.entry_index    = idx[4:0];
        it.entry_flags    = flags;
        it.entry_credit   = cr;
        it.entry_priority = pr;
        it.entry_wake     = wake;
        it.now            = $urandom;
        request_q.push_back(it);
    endtask

    task automatic add_sched(logic [31:0] now);
        mcpp_pkg::req_t it;
        it = '0;
        it.func           = mcpp_pkg::FUNC_SCHED;
        it.entry_index    = 5'($urandom);
        it.entry_flags    = 4'($urandom);
        it.entry_credit   = 8'($urandom);
        it.entry_priority = 8'($urandom);
        it.entry_wake     = $urandom;
        it.now            = now;
        request_q.push_back(it);
    endtask

    function automatic logic [3:0] rand_flags();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 4'd0;
        if (r < 60)
            return mcpp_pkg::FLAG_SLEEP;
        if (r < 75)
            return mcpp_pkg::FLAG_FREE;
        return 4'($urandom);
    endfunction

    task automatic build_stimulus();
        logic [31:0] tick;
        logic [31:0] live;
        logic [3:0]  fl;
        logic [31:0] wk;
        int          idx;
        int          n;

        // directed part
        add_sched(32'd0);                                   // empty table
        add_write(0, 4'd0, 8'd0, 8'd0, 32'd0);
        add_sched(32'd0);                                   // reload, all priorities zero
        add_write(31, 4'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        add_sched(32'hFFFF_FFFF);
        add_write(5, 4'd0, 8'hFF, 8'd1, 32'd0);
        add_sched(32'd0);                                   // tie goes to lower index
        add_write(3, mcpp_pkg::FLAG_SLEEP, 8'hFF, 8'd7, 32'd1000);
        add_sched(32'd999);                                 // still asleep
        add_sched(32'd1000);                                // wakes exactly on time
        add_write(3, 4'hF, 8'hFF, 8'd200, 32'd0);
        add_sched(32'd0);                                   // sleep cleared, still blocked
        add_write(7, 4'd2, 8'hFF, 8'hFF, 32'd0);
        add_write(9, 4'd4, 8'hFF, 8'hFF, 32'd0);
        add_write(31, mcpp_pkg::FLAG_FREE, 8'hFF, 8'hFF, 32'd0);
        add_write(5, 4'd0, 8'd0, 8'd100, 32'd0);
        add_sched(32'd5);                                   // reload picks 5 again
        add_write(12, mcpp_pkg::FLAG_SLEEP, 8'd50, 8'd50, 32'hFFFF_FFFF);
        add_sched(32'hFFFF_FFFE);
        add_sched(32'hFFFF_FFFF);

        // random part, tracking which entries could still become ready
        live = 32'h0000_1029;
        tick = $urandom_range(0, 1000);
        while (request_q.size() < ITEMS)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                n = $urandom_range(3, 8);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 99) < 50)
                    begin
                        idx = $urandom_range(0, NUM - 1);
                        fl = rand_flags();
                        wk = ($urandom_range(0, 99) < 15) ? 32'($urandom)
                                                          : tick + $urandom_range(0, 60);
                        add_write(idx, fl, ($urandom_range(0, 99) < 40) ? 8'd0 : 8'($urandom),
                                  ($urandom_range(0, 99) < 20) ? 8'd0 : 8'($urandom), wk);
                        live[idx] = ((fl & 4'b1110) == 4'd0);
                    end
                    else if ($urandom_range(0, 99) < 10)
                    begin
                        add_sched($urandom);
                    end
                    else
                    begin
                        tick = tick + $urandom_range(0, 20);
                        add_sched(tick);
                    end
                end
            end
            else
            begin
                // drain credit from every live entry so the reload path runs
                for (int i = 0; i < NUM; i++)
                begin
                    if (live[i])
                    begin
                        fl = rand_flags();
                        add_write(i, fl, 8'd0,
                                  ($urandom_range(0, 99) < 30) ? 8'd0 : 8'($urandom),
                                  tick + $urandom_range(0, 40));
                        live[i] = ((fl & 4'b1110) == 4'd0);
                    end
                end
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                begin
                    tick = tick + $urandom_range(0, 30);
                    add_sched(tick);
                end
            end
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            send_gap = 0;
            for (int i = 0; i < NUM; i++)
            begin
                tbl_flags[i]  = mcpp_pkg::FLAG_FREE;
                tbl_credit[i] = 8'd0;
                tbl_prio[i]   = 8'd0;
                tbl_wake[i]   = 32'd0;
            end
            cur_pick = 5'd0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_picks.push_back(predict_pick(request_q[0]));
                void'(request_q.pop_front());
                sent_count <= sent_count + 1;
                send_gap = next_gap();
            end
            // an offered item stays put until its transfer
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0 || request_q.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    req_if.valid <= 1'b0;
                end
                else
                begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= request_q[0];
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active <= 1'b0;
            hold_cycles <= 0;
        end
        else if (hold_active)
        begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HOLD_LEN - 1)
                hold_active <= 1'b0;
        end
        else if (hold_cycles == 0 && sent_count >= HOLD_AT)
        begin
            hold_active <= 1'b1;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                check_pick(rsp_if.data);
                recv_gap = next_gap();
            end
            if (hold_active || recv_gap > 0)
            begin
                if (recv_gap > 0)
                    recv_gap--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        build_stimulus();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
